### src/tlc_pkg.sv
package tlc_pkg;

	localparam int MAX_NODES_DEF = 64;

	localparam int PAR_W  = 7;  // stored parent entry, bit 6 = negative
	localparam int PIDX_W = 6;  // index bits of a parent entry
	localparam int DEL_W  = 6;
	localparam int LEAF_W = 7;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic load;         // store next parent entry
		logic query_start;  // latch victim, clear counters
		logic clr;          // clear child flag at u
		logic mark_rd;      // read parent of u for child marking
		logic walk_start;   // begin ancestor walk at u
		logic walk_step;    // follow parent pointer
		logic node_next;    // close node u, count if leaf
	} cmd_t;

	typedef struct packed {
		logic empty;     // no nodes loaded
		logic last;      // u is the last node
		logic hit;       // walk reached the deleted node
		logic walk_end;  // chain ended or step limit reached
	} sts_t;

endpackage

### src/tlc_ctrl.sv
module tlc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           op,
	input  tlc_pkg::sts_t  sts,
	output tlc_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLR   = 3'd1;
	localparam logic [2:0] S_MARK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_START = 3'd4;
	localparam logic [2:0] S_WALK  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (op == tlc_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.query_start = 1'b1;
						state_d = sts.empty ? S_DONE : S_CLR;
					end
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.last)
					state_d = S_MARK;
			end
			S_MARK: begin
				cmd.mark_rd = 1'b1;
				if (sts.last)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_START;
			S_START: begin
				cmd.walk_start = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				if (sts.hit || sts.walk_end) begin
					cmd.node_next = 1'b1;
					state_d = sts.last ? S_DONE : S_START;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

### src/tlc_dp.sv
module tlc_dp #(
	parameter int MAX_NODES = tlc_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlc_pkg::cmd_t                     cmd,
	input  logic signed [tlc_pkg::PAR_W-1:0]  parent_index,
	input  logic [tlc_pkg::DEL_W-1:0]         deleted_node,
	output tlc_pkg::sts_t                     sts,
	output logic [tlc_pkg::LEAF_W-1:0]        leaf_count
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int NC_W  = $clog2(MAX_NODES + 1);
	localparam int CMP_W = (NC_W > tlc_pkg::PIDX_W) ? NC_W : tlc_pkg::PIDX_W;
	localparam int VC_W  = (IDX_W > tlc_pkg::DEL_W) ? IDX_W : tlc_pkg::DEL_W;

	logic [tlc_pkg::PAR_W-1:0] par_mem [MAX_NODES];
	logic                      flag_mem [MAX_NODES];

	logic [NC_W-1:0]            node_count_q;
	logic                       new_tree_q;
	logic [tlc_pkg::DEL_W-1:0]  victim_q;
	logic [IDX_W-1:0]           u_q;
	logic [IDX_W-1:0]           cur_q;
	logic [NC_W-1:0]            step_q;
	logic [tlc_pkg::LEAF_W-1:0] leaves_q;
	logic [tlc_pkg::PAR_W-1:0]  rd_q;
	logic                       flag_rd_q;
	logic                       mark_v_s1;
	logic [IDX_W-1:0]           w_s1;

	logic [CMP_W-1:0]  p_full;
	logic              p_valid;
	logic [IDX_W-1:0]  p_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic              can_load;
	logic              fl_we;
	logic [IDX_W-1:0]  fl_addr;
	logic              fl_val;
	logic              mark_hit;

	// Parent entry decode: negative or out-of-range ends the chain
	assign p_full  = CMP_W'(rd_q[tlc_pkg::PIDX_W-1:0]);
	assign p_valid = !rd_q[tlc_pkg::PAR_W-1] && (p_full < CMP_W'(node_count_q));
	assign p_idx   = p_full[IDX_W-1:0];

	assign rd_addr = cmd.walk_step ? p_idx : u_q;

	assign can_load = new_tree_q || (node_count_q < NC_W'(MAX_NODES));
	assign wr_en    = cmd.load && can_load;
	assign wr_addr  = new_tree_q ? '0 : node_count_q[IDX_W-1:0];

	// self-parent and the deleted node itself never count as a live child
	assign mark_hit = mark_v_s1 && p_valid && (p_idx != w_s1)
		&& (VC_W'(w_s1) != VC_W'(victim_q));
	assign fl_we    = cmd.clr || mark_hit;
	assign fl_addr  = cmd.clr ? u_q : p_idx;
	assign fl_val   = !cmd.clr;

	always_ff @(posedge clk) begin
		if (wr_en)
			par_mem[wr_addr] <= parent_index;
		rd_q <= par_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (fl_we)
			flag_mem[fl_addr] <= fl_val;
		if (cmd.walk_start)
			flag_rd_q <= flag_mem[u_q];
	end

	always_ff @(posedge clk) begin
		w_s1 <= u_q;
		if (cmd.query_start)
			victim_q <= deleted_node;
		if (cmd.walk_start) begin
			cur_q  <= u_q;
			step_q <= '0;
		end else if (cmd.walk_step) begin
			cur_q  <= p_idx;
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			new_tree_q   <= 1'b1;
			u_q          <= '0;
			leaves_q     <= '0;
			mark_v_s1    <= 1'b0;
		end else begin
			mark_v_s1 <= cmd.mark_rd;
			if (wr_en) begin
				node_count_q <= new_tree_q ? NC_W'(1) : node_count_q + 1'b1;
				new_tree_q   <= 1'b0;
			end else if (cmd.load) begin
				new_tree_q <= 1'b0;
			end
			if (cmd.query_start) begin
				new_tree_q <= 1'b1;
				u_q        <= '0;
				leaves_q   <= '0;
			end else if (cmd.clr || cmd.mark_rd) begin
				u_q <= sts.last ? '0 : u_q + 1'b1;
			end else if (cmd.node_next) begin
				u_q <= u_q + 1'b1;
				if (!sts.hit && !flag_rd_q)
					leaves_q <= leaves_q + 1'b1;
			end
		end
	end

	always_comb begin
		sts.empty    = (node_count_q == '0);
		sts.last     = (NC_W'(u_q) + 1'b1 == node_count_q);
		sts.hit      = (VC_W'(cur_q) == VC_W'(victim_q));
		sts.walk_end = !p_valid || (step_q == node_count_q);
	end

	assign leaf_count = leaves_q;

endmodule

### src/tree_leaf_count_after_prune.sv
// channel   signals                                   handshake
// request   op, parent_index, deleted_node            taken when start && !busy
// result    leaf_count                                valid for one cycle with done
//
// A load leaves busy low. A query runs a child-flag clear pass, a marking
// pass over the parent table, then one ancestor walk per node, one
// parent-table read per step. A query on an empty tree goes straight to done.
// Reset clears counters and control only; the parent table needs no clearing.
// The receiver cannot stall: done lasts exactly one cycle.
module tree_leaf_count_after_prune #(
	parameter int MAX_NODES = tlc_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [tlc_pkg::PAR_W-1:0]  parent_index,
	input  logic [tlc_pkg::DEL_W-1:0]         deleted_node,
	output logic                              done,
	output logic [tlc_pkg::LEAF_W-1:0]        leaf_count
);

	tlc_pkg::cmd_t cmd;
	tlc_pkg::sts_t sts;

	tlc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tlc_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.parent_index (parent_index),
		.deleted_node (deleted_node),
		.sts          (sts),
		.leaf_count   (leaf_count)
	);

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == tlc_pkg::OP_LOAD) |=> !busy)
		else $error("load request left the block busy");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block did not return to idle after result");

	a_busy_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && op == tlc_pkg::OP_QUERY))
		else $error("busy rose without a query request");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a query");

endmodule

### test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES      = tlc_pkg::MAX_NODES_DEF;
	localparam int PAR_W      = tlc_pkg::PAR_W;
	localparam int PIDX_W     = tlc_pkg::PIDX_W;
	localparam int DEL_W      = tlc_pkg::DEL_W;
	localparam int LEAF_W     = tlc_pkg::LEAF_W;
	localparam int ITEMS      = 800;
	localparam int WD_LIMIT   = 20000;
	localparam int DRAIN_WAIT = 200;

	typedef struct packed {
		logic                     op;
		logic signed [PAR_W-1:0]  parent;
		logic [DEL_W-1:0]         victim;
	} req_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     op = tlc_pkg::OP_LOAD;
	logic signed [PAR_W-1:0]  parent_index = '0;
	logic [DEL_W-1:0]         deleted_node = '0;
	logic                     busy;
	logic                     done;
	logic [LEAF_W-1:0]        leaf_count;

	tree_leaf_count_after_prune uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.parent_index (parent_index),
		.deleted_node (deleted_node),
		.done         (done),
		.leaf_count   (leaf_count)
	);

	always #5 clk = ~clk;

	req_t               req_q[$];
	logic [LEAF_W-1:0]  expected_leaves[$];

	// predictor state
	logic [PAR_W-1:0]   tree_nodes[NODES];
	int                 tree_size = 0;
	bit                 restart_tree = 1'b1;

	int idle_pct = 0;
	int n_pushed = 0;
	int n_loads = 0;
	int n_queries = 0;
	int n_checked = 0;
	int errors = 0;
	int idle_cycles = 0;

	function automatic int parent_link(input int v);
		int p;
		if (tree_nodes[v][PAR_W-1])
			return -1;
		p = int'(tree_nodes[v][PIDX_W-1:0]);
		if (p >= tree_size)
			return -1;
		return p;
	endfunction

	function automatic logic [LEAF_W-1:0] count_leaves(input logic [DEL_W-1:0] victim);
		bit gone[NODES];
		int cur;
		int total;
		bit has_kid;
		total = 0;
		for (int u = 0; u < tree_size; u++) begin
			gone[u] = 1'b0;
			cur = u;
			// walk is bounded so parent cycles terminate
			for (int s = 0; s <= tree_size; s++) begin
				if (cur == int'(victim)) begin
					gone[u] = 1'b1;
					break;
				end
				cur = parent_link(cur);
				if (cur < 0)
					break;
			end
		end
		for (int u = 0; u < tree_size; u++) begin
			if (!gone[u]) begin
				has_kid = 1'b0;
				for (int w = 0; w < tree_size; w++)
					if (w != u && !gone[w] && parent_link(w) == u)
						has_kid = 1'b1;
				if (!has_kid)
					total++;
			end
		end
		return total[LEAF_W-1:0];
	endfunction

	task automatic push_req(input logic o, input logic signed [PAR_W-1:0] p,
			input logic [DEL_W-1:0] d);
		req_t r;
		r.op = o;
		r.parent = p;
		r.victim = d;
		req_q.push_back(r);
		n_pushed++;
	endtask

	// style 0: random tree, 1: chain, 2: star, 3: forest, 4: corrupted entries
	task automatic queue_tree(input int n, input int style);
		logic signed [PAR_W-1:0] p;
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				p = -7'sd1;
			else begin
				case (style)
					1: p = PAR_W'(i - 1);
					2: p = '0;
					3: p = ($urandom_range(99) < 20) ? -7'sd1
						: PAR_W'($urandom_range(i - 1));
					4: p = ($urandom_range(99) < 30) ? PAR_W'($urandom_range(127))
						: PAR_W'($urandom_range(i - 1));
					default: p = PAR_W'($urandom_range(i - 1));
				endcase
			end
			push_req(tlc_pkg::OP_LOAD, p, DEL_W'($urandom_range(63)));
		end
	endtask

	task automatic queue_random(input int upto);
		int r;
		int n;
		int live;
		while (n_pushed < upto) begin
			r = $urandom_range(99);
			if (r < 10) begin
				// noise: loose mix of loads and queries
				repeat ($urandom_range(1, 4))
					push_req(1'($urandom_range(1)), PAR_W'($urandom_range(127)),
						DEL_W'($urandom_range(63)));
			end else begin
				r = $urandom_range(99);
				if (r < 90)
					n = $urandom_range(1, 12);
				else if (r < 97)
					n = $urandom_range(13, 40);
				else
					n = $urandom_range(60, 70);
				queue_tree(n, $urandom_range(4));
				live = (n > NODES) ? NODES : n;
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(99) < 80)
						push_req(tlc_pkg::OP_QUERY, PAR_W'($urandom_range(127)),
							DEL_W'($urandom_range(live - 1)));
					else
						push_req(tlc_pkg::OP_QUERY, PAR_W'($urandom_range(127)),
							DEL_W'($urandom_range(63)));
				end
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin : drive
		req_t nxt;
		bit   holding;
		if (!arst_n)
			start <= 1'b0;
		else begin
			holding = start;
			if (start && !busy) begin
				holding = 1'b0;
				if (op == tlc_pkg::OP_LOAD) begin
					if (restart_tree) begin
						tree_size = 0;
						restart_tree = 1'b0;
					end
					if (tree_size < NODES) begin
						tree_nodes[tree_size] = parent_index;
						tree_size++;
					end
					n_loads++;
				end else begin
					restart_tree = 1'b1;
					expected_leaves.push_back(count_leaves(deleted_node));
					n_queries++;
				end
			end
			if (!holding) begin
				if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					nxt = req_q.pop_front();
					start <= 1'b1;
					op <= nxt.op;
					parent_index <= nxt.parent;
					deleted_node <= nxt.victim;
				end else begin
					start <= 1'b0;
					op <= 1'($urandom_range(1));
					parent_index <= PAR_W'($urandom_range(127));
					deleted_node <= DEL_W'($urandom_range(63));
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : monitor
		logic [LEAF_W-1:0] want;
		if (arst_n && done) begin
			if (expected_leaves.size() == 0) begin
				$display("%0t: unexpected done, leaf_count %0d", $time, leaf_count);
				errors++;
			end else begin
				want = expected_leaves.pop_front();
				n_checked++;
				if (leaf_count !== want) begin
					$display("%0t: leaf_count expected %0d got %0d", $time, want, leaf_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WD_LIMIT);
		$display("%0t: watchdog, no request or result for %0d cycles", $time, WD_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stim
		int pct[4];
		pct[0] = 0;
		pct[1] = 62;
		pct[2] = 0;
		pct[3] = 21;

		// empty tree
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd0);
		// single root: delete it, then delete a node never loaded
		push_req(tlc_pkg::OP_LOAD, -7'sd1, 6'd0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd1);
		// small tree, repeated queries on the same table
		push_req(tlc_pkg::OP_LOAD, -7'sd1, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd0, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd0, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd1, 6'd0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd1);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd3);
		push_req(tlc_pkg::OP_QUERY, 7'sd63, 6'd63);
		// most negative parent, out-of-range parent, self parent, two-node cycle
		push_req(tlc_pkg::OP_LOAD, -7'sd64, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd63, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd2, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd4, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd3, 6'd0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd3);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd2);
		// forest with two roots
		push_req(tlc_pkg::OP_LOAD, -7'sd1, 6'd0);
		push_req(tlc_pkg::OP_LOAD, -7'sd1, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd0, 6'd0);
		push_req(tlc_pkg::OP_LOAD, 7'sd1, 6'd0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd0);
		// table overflow: loads past the limit are dropped
		queue_tree(NODES + 3, 0);
		push_req(tlc_pkg::OP_QUERY, 7'sd0, 6'd63);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pct[ph];
			queue_random((ph + 1) * ITEMS / 4);
			while (req_q.size() != 0)
				@(posedge clk);
		end

		while (start || expected_leaves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d loads and %0d queries sent over four idle settings", n_loads, n_queries);
		$display("%0d leaf counts checked, %0d errors", n_checked, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
